@@ rtl/vpa_pkg.sv @@
// package: types and constants for the variable partition allocator
package vpa_pkg;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_NO_OWNER = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_t;

    localparam logic [2:0] REG_FIT     = 3'd0;
    localparam logic [2:0] REG_A_COUNT = 3'd1;
    localparam logic [2:0] REG_A_SIZE  = 3'd2;
    localparam logic [2:0] REG_B_COUNT = 3'd3;
    localparam logic [2:0] REG_B_SIZE  = 3'd4;
    localparam logic [2:0] REG_C_COUNT = 3'd5;
    localparam logic [2:0] REG_C_SIZE  = 3'd6;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] request_units;
        logic [15:0] owner_id;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] partition_index;
        logic [5:0] partition_total;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_ALLOC,
        S_SHIFT_UP,
        S_SPLIT,
        S_FREE_L,
        S_FREE_R,
        S_SHIFT_DN,
        S_DONE
    } state_t;

endpackage

@@ rtl/variable_partition_allocator_unit.sv @@
// top level: partition table allocator with a shared scan and shift sequencer
//
// One item at a time. Init creates the partitions group by group, allocate
// and free scan the table and then move entries when the table is opened for
// a split or closed after a merge. The entry table lives in flip-flops and is
// stepped through by one index counter.
module variable_partition_allocator_unit #(
    parameter int MAX_PARTITIONS = 32,
    parameter int UNIT_WIDTH     = 12,
    parameter int OWNER_WIDTH    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  vpa_pkg::in_word_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output vpa_pkg::out_word_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [11:0]       cfg_data
);
    import vpa_pkg::*;

    localparam int IW = $clog2(MAX_PARTITIONS);
    localparam int CW = $clog2(MAX_PARTITIONS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_PARTITIONS);
    localparam logic [UNIT_WIDTH-1:0] UMAX = '1;

    logic [UNIT_WIDTH-1:0]  start_reg [MAX_PARTITIONS];
    logic [UNIT_WIDTH-1:0]  size_reg  [MAX_PARTITIONS];
    logic                   used_reg  [MAX_PARTITIONS];
    logic [OWNER_WIDTH-1:0] owner_reg [MAX_PARTITIONS];
    logic [CW-1:0]          count_reg;

    logic [1:0]  fit_reg;
    logic [5:0]  cnt_a_reg, cnt_b_reg, cnt_c_reg;
    logic [11:0] sz_a_reg, sz_b_reg, sz_c_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] tgt_reg, tgt_next;
    logic [1:0]    grp_reg, grp_next;
    logic [5:0]    gk_reg, gk_next;
    logic [UNIT_WIDTH-1:0] ustart_reg, ustart_next;
    logic          found_reg, found_next;
    logic [CW-1:0] sel_reg, sel_next;
    logic [UNIT_WIDTH-1:0] selsz_reg, selsz_next;
    logic [1:0]    act_reg;
    logic [UNIT_WIDTH-1:0] units_reg;
    logic [OWNER_WIDTH-1:0] own_reg;
    out_word_t     res_reg, res_next;
    logic          ov_reg, ov_next;

    logic [IW-1:0] ia, ib;
    logic [5:0]    gcnt;
    logic [UNIT_WIDTH-1:0] gsz;
    logic [UNIT_WIDTH:0]   ssum;
    logic [UNIT_WIDTH-1:0] sat;
    logic          cand, better;

    // table write controls
    logic          wr_en, wr_copy, wr_clear;
    logic [IW-1:0] wr_idx, wr_src;
    logic [UNIT_WIDTH-1:0] wr_start, wr_size;
    logic          wr_used;
    logic [OWNER_WIDTH-1:0] wr_owner;
    logic          sz_en;
    logic [IW-1:0] sz_idx;
    logic [UNIT_WIDTH-1:0] sz_val;
    logic          cnt_en;
    logic [CW-1:0] cnt_val;

    assign cfg_ready = (state_reg == S_IDLE) && !ov_reg;
    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = res_reg;

    assign ia = idx_reg[IW-1:0];
    assign ib = IW'(idx_reg - CW'(1));

    always_comb
    begin
        case (grp_reg)
            2'd0:    begin gcnt = cnt_a_reg; gsz = UNIT_WIDTH'(sz_a_reg); end
            2'd1:    begin gcnt = cnt_b_reg; gsz = UNIT_WIDTH'(sz_b_reg); end
            default: begin gcnt = cnt_c_reg; gsz = UNIT_WIDTH'(sz_c_reg); end
        endcase
    end

    assign ssum = {1'b0, size_reg[ib]} + {1'b0, size_reg[ia]};
    assign sat  = ssum[UNIT_WIDTH] ? UMAX : ssum[UNIT_WIDTH-1:0];
    assign cand = !used_reg[ia] && (size_reg[ia] >= units_reg);
    always_comb
    begin
        case (fit_reg)
            FIT_BEST:  better = size_reg[ia] < selsz_reg;
            FIT_WORST: better = size_reg[ia] > selsz_reg;
            default:   better = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg; tgt_next = tgt_reg; grp_next = grp_reg; gk_next = gk_reg;
        ustart_next = ustart_reg; found_next = found_reg; sel_next = sel_reg;
        selsz_next = selsz_reg; res_next = res_reg; ov_next = ov_reg;
        wr_en = 1'b0; wr_copy = 1'b0; wr_clear = 1'b0;
        wr_idx = ia; wr_src = ib; wr_start = ustart_reg; wr_size = gsz;
        wr_used = 1'b0; wr_owner = '0;
        sz_en = 1'b0; sz_idx = ia; sz_val = sat;
        cnt_en = 1'b0; cnt_val = count_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0; grp_next = '0; gk_next = '0; ustart_next = '0;
                found_next = 1'b0;
                if (in_valid && !ov_reg)
                begin
                    case (in_data.action)
                        ACT_INIT:
                        begin
                            cnt_en = 1'b1; cnt_val = '0;
                            state_next = S_INIT;
                        end
                        ACT_ALLOC, ACT_FREE: state_next = S_SCAN;
                        default:
                        begin
                            res_next = '{ST_OK, 5'd0, 6'(count_reg)};
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                if (grp_reg == 2'd3 || idx_reg == MAXC)
                    state_next = S_DONE;
                else if (gk_reg >= gcnt)
                begin
                    grp_next = grp_reg + 2'd1; gk_next = '0;
                end
                else
                begin
                    wr_en = 1'b1;
                    cnt_en = 1'b1; cnt_val = idx_reg + CW'(1);
                    idx_next = idx_reg + CW'(1);
                    gk_next = gk_reg + 6'd1;
                    ustart_next = ustart_reg + gsz;
                end
                res_next = '{ST_OK, 5'd0, 6'(cnt_en ? cnt_val : count_reg)};
            end
            S_SCAN:
            begin
                if (idx_reg >= count_reg || (found_reg && act_reg == ACT_FREE))
                begin
                    if (!found_reg)
                    begin
                        res_next = '{(act_reg == ACT_FREE) ? ST_NO_OWNER : ST_NO_FIT,
                                     5'd0, 6'(count_reg)};
                        state_next = S_DONE;
                    end
                    else if (act_reg == ACT_ALLOC)
                        state_next = S_ALLOC;
                    else
                    begin
                        idx_next = sel_reg;
                        state_next = S_FREE_L;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    if (act_reg == ACT_FREE)
                    begin
                        if (used_reg[ia] && owner_reg[ia] == own_reg)
                        begin
                            found_next = 1'b1; sel_next = idx_reg;
                        end
                    end
                    else if (cand && (!found_reg || better))
                    begin
                        found_next = 1'b1; sel_next = idx_reg; selsz_next = size_reg[ia];
                        if (fit_reg != FIT_BEST && fit_reg != FIT_WORST)
                            idx_next = count_reg;
                    end
                end
            end
            S_ALLOC:
            begin
                wr_en = 1'b1; wr_idx = sel_reg[IW-1:0];
                wr_start = start_reg[sel_reg[IW-1:0]]; wr_size = selsz_reg;
                wr_used = 1'b1; wr_owner = own_reg;
                res_next = '{ST_OK, 5'(sel_reg), 6'(count_reg)};
                if (selsz_reg != units_reg && count_reg != MAXC)
                begin
                    wr_size = units_reg;
                    idx_next = count_reg;
                    res_next.partition_total = 6'(count_reg + CW'(1));
                    state_next = S_SHIFT_UP;
                end
                else
                    state_next = S_DONE;
            end
            S_SHIFT_UP:
            begin
                if (idx_reg > sel_reg + CW'(1))
                begin
                    wr_en = 1'b1; wr_copy = 1'b1;
                    idx_next = idx_reg - CW'(1);
                end
                else
                    state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                wr_en = 1'b1; wr_idx = IW'(sel_reg + CW'(1));
                wr_start = start_reg[sel_reg[IW-1:0]] + units_reg;
                wr_size = selsz_reg - units_reg;
                cnt_en = 1'b1; cnt_val = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_FREE_L:
            begin
                wr_en = 1'b1; wr_clear = 1'b1;
                if (idx_reg != '0 && !used_reg[ib])
                begin
                    sz_en = 1'b1; sz_idx = ib;
                    sel_next = idx_reg - CW'(1);
                    tgt_next = idx_reg - CW'(1);
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    sel_next = idx_reg;
                    idx_next = idx_reg + CW'(1);
                    grp_next = 2'd1;
                    state_next = S_FREE_R;
                end
            end
            S_FREE_R:
            begin
                // idx points at the right neighbor of sel
                if (idx_reg < count_reg && !used_reg[ia])
                begin
                    sz_en = 1'b1; sz_idx = ib;
                    tgt_next = sel_reg;
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    res_next = '{ST_OK, 5'(sel_reg), 6'(count_reg)};
                    state_next = S_DONE;
                end
            end
            S_SHIFT_DN:
            begin
                // remove entry idx by pulling entries down
                if (idx_reg + CW'(1) < count_reg)
                begin
                    wr_en = 1'b1; wr_copy = 1'b1; wr_src = IW'(idx_reg + CW'(1));
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    cnt_en = 1'b1; cnt_val = count_reg - CW'(1);
                    if (tgt_reg == sel_reg && found_reg && act_reg == ACT_FREE
                        && sel_reg + CW'(1) != idx_reg + CW'(1) && grp_reg == 2'd0)
                    begin
                        grp_next = 2'd1;
                        idx_next = sel_reg + CW'(1);
                        state_next = S_FREE_R;
                    end
                    else
                    begin
                        res_next = '{ST_OK, 5'(sel_reg), 6'(count_reg - CW'(1))};
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            count_reg <= '0;
            fit_reg   <= 2'd1;
            cnt_a_reg <= 6'd2; sz_a_reg <= 12'd8;
            cnt_b_reg <= 6'd2; sz_b_reg <= 12'd6;
            cnt_c_reg <= 6'd4; sz_c_reg <= 12'd4;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cnt_en)
                count_reg <= cnt_val;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FIT:     fit_reg   <= cfg_data[1:0];
                    REG_A_COUNT: cnt_a_reg <= cfg_data[5:0];
                    REG_A_SIZE:  sz_a_reg  <= cfg_data;
                    REG_B_COUNT: cnt_b_reg <= cfg_data[5:0];
                    REG_B_SIZE:  sz_b_reg  <= cfg_data;
                    REG_C_COUNT: cnt_c_reg <= cfg_data[5:0];
                    REG_C_SIZE:  sz_c_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; tgt_reg <= tgt_next; grp_reg <= grp_next;
        gk_reg <= gk_next; ustart_reg <= ustart_next; found_reg <= found_next;
        sel_reg <= sel_next; selsz_reg <= selsz_next; res_reg <= res_next;
        if (state_reg == S_IDLE && in_valid && !ov_reg)
        begin
            act_reg   <= in_data.action;
            units_reg <= UNIT_WIDTH'(in_data.request_units);
            own_reg   <= OWNER_WIDTH'(in_data.owner_id);
        end
        if (wr_en)
        begin
            if (wr_copy)
            begin
                start_reg[wr_idx] <= start_reg[wr_src];
                size_reg[wr_idx]  <= size_reg[wr_src];
                used_reg[wr_idx]  <= used_reg[wr_src];
                owner_reg[wr_idx] <= owner_reg[wr_src];
            end
            else if (wr_clear)
            begin
                used_reg[wr_idx]  <= 1'b0;
                owner_reg[wr_idx] <= '0;
            end
            else
            begin
                start_reg[wr_idx] <= wr_start;
                size_reg[wr_idx]  <= wr_size;
                used_reg[wr_idx]  <= wr_used;
                owner_reg[wr_idx] <= wr_owner;
            end
        end
        if (sz_en)
            size_reg[sz_idx] <= sz_val;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("accept while busy");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAXC)
        else $error("count overflow");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("result dropped");
endmodule
